// ----- rtl/act_pkg.sv -----
// Shared constants, types and helpers for the advertiser churn tracker.
// Used by act_ctrl, act_dp and advertiser_churn_tracker_unit; no dependencies.
`timescale 1ns / 1ps

package act_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 256;

    localparam int ADDR_W  = 48;
    localparam int TYPE_W  = 2;
    localparam int KEY_W   = ADDR_W + TYPE_W;
    localparam int CODE_W  = 16;
    localparam int CNT32_W = 32;
    localparam int OUTCNT_W = 9;

    localparam logic [CODE_W-1:0] CID_A       = 16'h004C;
    localparam logic [CODE_W-1:0] CID_B       = 16'h0006;
    localparam logic [CODE_W-1:0] CID_C       = 16'h00E0;
    localparam logic [CODE_W-1:0] CID_D       = 16'h0075;
    localparam logic [CODE_W-1:0] SVC_PAIRING = 16'hFE2C;

    localparam logic [TYPE_W-1:0] ATYPE_RANDOM    = 2'd1;
    localparam logic [TYPE_W-1:0] ATYPE_RANDOM_ID = 2'd3;

    localparam logic MODE_CLEAR = 1'b1;

    localparam logic [CNT32_W-1:0] SAT32 = 32'hFFFF_FFFF;

    // controller -> datapath
    typedef struct packed {
        logic start;        // latch advert, bump tallies, rewind search
        logic clear;        // new window
        logic scan;         // search pipeline running
        logic commit_hit;   // update matching entry
        logic commit_miss;  // append new entry or flag overflow
        logic load_out;     // snapshot statistics into result register
    } act_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic miss;
        logic out_free;
    } act_status_t;

    function automatic logic [CNT32_W-1:0] sat_inc(input logic [CNT32_W-1:0] v);
        sat_inc = (v == SAT32) ? v : v + 32'd1;
    endfunction

endpackage

// ----- rtl/advertiser_churn_tracker_unit.sv -----
// Advertiser churn tracker: counts adverts per window, tallies vendors and the
// pairing service, and tracks distinct advertiser addresses in a searched table.
//
// Input channel (s_*): one beat per advert, or a clear beat (s_mode = 1) that
// zeroes every statistic and starts a new window; other fields are then ignored.
// Result channel (m_*): exactly one beat per input beat, carrying the statistics
// as they stand after that input.
// Timing: the table is scanned one entry per cycle through a registered read port.
// A hit on entry i loads its result once entry i has been read back and matched;
// a miss loads it once all fill entries have been read (none with an empty table),
// where fill is the number of entries held (at most TABLE_DEPTH). A clear beat goes
// straight to the result load. After the load the block returns to idle and can
// accept the next beat. s_ready is high only while idle.
// The result sits in an output register, so a new beat is accepted while the
// previous result waits; if the receiver stalls, the next result is held back
// and no further beat is accepted until the register frees up.
// Reset (aresetn low, synchronous) empties the table and zeroes all counters;
// table memory is not swept, entries beyond the fill count are never read.
`timescale 1ns / 1ps

module advertiser_churn_tracker_unit #(
    parameter int TABLE_DEPTH = act_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_mode,
    input  logic [act_pkg::ADDR_W-1:0]    s_advertiser_address,
    input  logic [act_pkg::TYPE_W-1:0]    s_address_type,
    input  logic                          s_company_present,
    input  logic [act_pkg::CODE_W-1:0]    s_company_code,
    input  logic                          s_service_present,
    input  logic [act_pkg::CODE_W-1:0]    s_service_code,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [act_pkg::CNT32_W-1:0]   m_total_adverts,
    output logic [act_pkg::OUTCNT_W-1:0]  m_unique_count,
    output logic                          m_table_overflow,
    output logic [act_pkg::OUTCNT_W-1:0]  m_random_unique_count,
    output logic [act_pkg::CNT32_W-1:0]   m_busiest_hits,
    output logic [act_pkg::KEY_W-1:0]     m_top_advertiser,
    output logic [act_pkg::CNT32_W-1:0]   m_vendor_a_count,
    output logic [act_pkg::CNT32_W-1:0]   m_vendor_b_count,
    output logic [act_pkg::CNT32_W-1:0]   m_vendor_c_count,
    output logic [act_pkg::CNT32_W-1:0]   m_vendor_d_count,
    output logic [act_pkg::CNT32_W-1:0]   m_pairing_service_count,
    output logic [act_pkg::CNT32_W-1:0]   m_other_vendor_count
);
    import act_pkg::*;

    act_cmd_t    cmd;
    act_status_t status;

    act_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    act_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .cmd                     (cmd),
        .status                  (status),
        .s_advertiser_address    (s_advertiser_address),
        .s_address_type          (s_address_type),
        .s_company_present       (s_company_present),
        .s_company_code          (s_company_code),
        .s_service_present       (s_service_present),
        .s_service_code          (s_service_code),
        .m_ready                 (m_ready),
        .m_valid                 (m_valid),
        .m_total_adverts         (m_total_adverts),
        .m_unique_count          (m_unique_count),
        .m_table_overflow        (m_table_overflow),
        .m_random_unique_count   (m_random_unique_count),
        .m_busiest_hits          (m_busiest_hits),
        .m_top_advertiser        (m_top_advertiser),
        .m_vendor_a_count        (m_vendor_a_count),
        .m_vendor_b_count        (m_vendor_b_count),
        .m_vendor_c_count        (m_vendor_c_count),
        .m_vendor_d_count        (m_vendor_d_count),
        .m_pairing_service_count (m_pairing_service_count),
        .m_other_vendor_count    (m_other_vendor_count)
    );

    // one beat in flight: the block is busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while previous beat still in progress");

    // a result with no busiest entry carries a zero key
    a_top_key_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_busiest_hits == '0)) |-> (m_top_advertiser == '0))
        else $error("top advertiser set with zero busiest hit count");

    // a search ends in either a hit or a miss, never both
    a_single_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.commit_hit && cmd.commit_miss))
        else $error("hit and miss committed together");

endmodule

// ----- rtl/act_ctrl.sv -----
// Sequencer for the churn tracker: accept, table search, commit, result hand-off.
// Depends on act_pkg; drives act_dp through act_cmd_t.
`timescale 1ns / 1ps

module act_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_mode,
    output logic                 s_ready,
    input  act_pkg::act_status_t status,
    output act_pkg::act_cmd_t    cmd
);
    import act_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_mode == MODE_CLEAR) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.hit) begin
                    cmd.commit_hit = 1'b1;
                    state_next     = ST_OUT;
                end else if (status.miss) begin
                    cmd.commit_miss = 1'b1;
                    state_next      = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/act_dp.sv -----
// Datapath for the churn tracker: key/hit tables, search pipeline, counters,
// result register. Depends on act_pkg; sequenced by act_ctrl.
`timescale 1ns / 1ps

module act_dp #(
    parameter int TABLE_DEPTH = act_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  act_pkg::act_cmd_t             cmd,
    output act_pkg::act_status_t          status,
    input  logic [act_pkg::ADDR_W-1:0]    s_advertiser_address,
    input  logic [act_pkg::TYPE_W-1:0]    s_address_type,
    input  logic                          s_company_present,
    input  logic [act_pkg::CODE_W-1:0]    s_company_code,
    input  logic                          s_service_present,
    input  logic [act_pkg::CODE_W-1:0]    s_service_code,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic [act_pkg::CNT32_W-1:0]   m_total_adverts,
    output logic [act_pkg::OUTCNT_W-1:0]  m_unique_count,
    output logic                          m_table_overflow,
    output logic [act_pkg::OUTCNT_W-1:0]  m_random_unique_count,
    output logic [act_pkg::CNT32_W-1:0]   m_busiest_hits,
    output logic [act_pkg::KEY_W-1:0]     m_top_advertiser,
    output logic [act_pkg::CNT32_W-1:0]   m_vendor_a_count,
    output logic [act_pkg::CNT32_W-1:0]   m_vendor_b_count,
    output logic [act_pkg::CNT32_W-1:0]   m_vendor_c_count,
    output logic [act_pkg::CNT32_W-1:0]   m_vendor_d_count,
    output logic [act_pkg::CNT32_W-1:0]   m_pairing_service_count,
    output logic [act_pkg::CNT32_W-1:0]   m_other_vendor_count
);
    import act_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam int T_A     = 0;
    localparam int T_B     = 1;
    localparam int T_C     = 2;
    localparam int T_D     = 3;
    localparam int T_PAIR  = 4;
    localparam int T_OTHER = 5;
    localparam int N_TALLY = 6;

    // tables
    logic [KEY_W-1:0]   key_mem [TABLE_DEPTH];
    logic [CNT32_W-1:0] hit_mem [TABLE_DEPTH];

    // statistics
    logic [CNT_W-1:0]   fill_reg,   fill_next;
    logic               full_reg,   full_next;
    logic [CNT32_W-1:0] total_reg,  total_next;
    logic [CNT_W-1:0]   random_reg, random_next;
    logic [CNT32_W-1:0] busy_hits_reg, busy_hits_next;
    logic [KEY_W-1:0]   top_key_reg,   top_key_next;
    logic [CNT32_W-1:0] tally_reg  [N_TALLY];
    logic [CNT32_W-1:0] tally_next [N_TALLY];

    // search pipeline
    logic [KEY_W-1:0]   key_lat_reg;
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               rd_vld_reg,   rd_vld_next;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [KEY_W-1:0]   key_rd_reg;
    logic [CNT32_W-1:0] hit_rd_reg;
    logic               rd_en;

    logic               key_we;
    logic [IDX_W-1:0]   key_waddr;
    logic               hit_we;
    logic [IDX_W-1:0]   hit_waddr;
    logic [CNT32_W-1:0] hit_wdata;
    logic [CNT32_W-1:0] bumped_hits;
    logic               table_full;
    logic               m_valid_reg;

    assign rd_en       = cmd.scan && (scan_idx_reg < fill_reg);
    assign bumped_hits = sat_inc(hit_rd_reg);
    assign table_full  = (fill_reg >= CNT_W'(TABLE_DEPTH));

    assign status.hit      = rd_vld_reg && (key_rd_reg == key_lat_reg);
    assign status.miss     = !rd_vld_reg && (scan_idx_reg >= fill_reg);
    assign status.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            key_rd_reg <= key_mem[scan_idx_reg[IDX_W-1:0]];
            hit_rd_reg <= hit_mem[scan_idx_reg[IDX_W-1:0]];
            rd_idx_reg <= scan_idx_reg[IDX_W-1:0];
        end
        if (key_we) begin
            key_mem[key_waddr] <= key_lat_reg;
        end
        if (hit_we) begin
            hit_mem[hit_waddr] <= hit_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            key_lat_reg <= {s_address_type, s_advertiser_address};
        end
    end

    always_comb begin
        fill_next      = fill_reg;
        full_next      = full_reg;
        total_next     = total_reg;
        random_next    = random_reg;
        busy_hits_next = busy_hits_reg;
        top_key_next   = top_key_reg;
        for (int i = 0; i < N_TALLY; i++) begin
            tally_next[i] = tally_reg[i];
        end
        scan_idx_next = scan_idx_reg;
        rd_vld_next   = rd_vld_reg;
        key_we        = 1'b0;
        key_waddr     = fill_reg[IDX_W-1:0];
        hit_we        = 1'b0;
        hit_waddr     = rd_idx_reg;
        hit_wdata     = bumped_hits;

        if (cmd.clear) begin
            fill_next      = '0;
            full_next      = 1'b0;
            total_next     = '0;
            random_next    = '0;
            busy_hits_next = '0;
            top_key_next   = '0;
            for (int i = 0; i < N_TALLY; i++) begin
                tally_next[i] = '0;
            end
        end

        if (cmd.start) begin
            scan_idx_next = '0;
            rd_vld_next   = 1'b0;
            total_next    = sat_inc(total_reg);
            if (s_company_present) begin
                case (s_company_code)
                    CID_A:   tally_next[T_A]     = sat_inc(tally_reg[T_A]);
                    CID_B:   tally_next[T_B]     = sat_inc(tally_reg[T_B]);
                    CID_C:   tally_next[T_C]     = sat_inc(tally_reg[T_C]);
                    CID_D:   tally_next[T_D]     = sat_inc(tally_reg[T_D]);
                    default: tally_next[T_OTHER] = sat_inc(tally_reg[T_OTHER]);
                endcase
            end
            if (s_service_present && (s_service_code == SVC_PAIRING)) begin
                tally_next[T_PAIR] = sat_inc(tally_reg[T_PAIR]);
            end
        end

        if (cmd.scan) begin
            rd_vld_next = rd_en;
            if (rd_en) begin
                scan_idx_next = scan_idx_reg + CNT_W'(1);
            end
        end

        if (cmd.commit_hit) begin
            hit_we = 1'b1;
            // strictly greater: ties keep the current top entry
            if (bumped_hits > busy_hits_reg) begin
                busy_hits_next = bumped_hits;
                top_key_next   = key_lat_reg;
            end
        end

        if (cmd.commit_miss) begin
            if (table_full) begin
                full_next = 1'b1;
            end else begin
                key_we    = 1'b1;
                hit_we    = 1'b1;
                hit_waddr = fill_reg[IDX_W-1:0];
                hit_wdata = 32'd1;
                fill_next = fill_reg + CNT_W'(1);
                if ((key_lat_reg[KEY_W-1:ADDR_W] == ATYPE_RANDOM) ||
                    (key_lat_reg[KEY_W-1:ADDR_W] == ATYPE_RANDOM_ID)) begin
                    random_next = random_reg + CNT_W'(1);
                end
                if (busy_hits_reg == '0) begin
                    busy_hits_next = 32'd1;
                    top_key_next   = key_lat_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            full_reg      <= 1'b0;
            total_reg     <= '0;
            random_reg    <= '0;
            busy_hits_reg <= '0;
            top_key_reg   <= '0;
            for (int i = 0; i < N_TALLY; i++) begin
                tally_reg[i] <= '0;
            end
            scan_idx_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            fill_reg      <= fill_next;
            full_reg      <= full_next;
            total_reg     <= total_next;
            random_reg    <= random_next;
            busy_hits_reg <= busy_hits_next;
            top_key_reg   <= top_key_next;
            for (int i = 0; i < N_TALLY; i++) begin
                tally_reg[i] <= tally_next[i];
            end
            scan_idx_reg  <= scan_idx_next;
            rd_vld_reg    <= rd_vld_next;
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_total_adverts         <= total_reg;
            m_unique_count          <= OUTCNT_W'(fill_reg);
            m_table_overflow        <= full_reg;
            m_random_unique_count   <= OUTCNT_W'(random_reg);
            m_busiest_hits          <= busy_hits_reg;
            m_top_advertiser        <= top_key_reg;
            m_vendor_a_count        <= tally_reg[T_A];
            m_vendor_b_count        <= tally_reg[T_B];
            m_vendor_c_count        <= tally_reg[T_C];
            m_vendor_d_count        <= tally_reg[T_D];
            m_pairing_service_count <= tally_reg[T_PAIR];
            m_other_vendor_count    <= tally_reg[T_OTHER];
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- bench/tb_advertiser_churn_tracker_unit.sv -----
// Self-checking testbench for advertiser_churn_tracker_unit: a directed table, then ~1000
// random beats checked field by field against an in-bench predictor of the window stats.
// Depends on rtl/act_pkg.sv and rtl/advertiser_churn_tracker_unit.sv.
`timescale 1ns / 1ps

module tb_advertiser_churn_tracker_unit;
    import act_pkg::*;

    localparam int TABLE_DEPTH  = DEFAULT_TABLE_DEPTH;
    localparam int N_DIRECTED   = 14;
    localparam int N_RANDOM     = 1036;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 40;
    localparam int PRINT_CAP    = 40;

    localparam logic              MODE_ADVERT    = 1'b0;
    localparam logic [TYPE_W-1:0] ATYPE_PUBLIC    = 2'd0;
    localparam logic [TYPE_W-1:0] ATYPE_PUBLIC_ID = 2'd2;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] addr;
        logic [TYPE_W-1:0] atype;
        logic              co_present;
        logic [CODE_W-1:0] co_code;
        logic              svc_present;
        logic [CODE_W-1:0] svc_code;
    } advert_beat_t;

    typedef struct packed {
        logic [31:0]      total;
        logic [8:0]       uniq;
        logic             ovf;
        logic [8:0]       rnd;
        logic [31:0]      top_hits;
        logic [KEY_W-1:0] top_key;
        logic [31:0]      vend_a;
        logic [31:0]      vend_b;
        logic [31:0]      vend_c;
        logic [31:0]      vend_d;
        logic [31:0]      pairing;
        logic [31:0]      vend_other;
    } window_stats_t;

    typedef struct packed {
        advert_beat_t  beat;
        logic          typed;
        window_stats_t want;
    } directed_row_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic s_mode;
    logic [ADDR_W-1:0] s_advertiser_address;
    logic [TYPE_W-1:0] s_address_type;
    logic s_company_present;
    logic [CODE_W-1:0] s_company_code;
    logic s_service_present;
    logic [CODE_W-1:0] s_service_code;
    logic m_valid;
    logic m_ready;
    logic [CNT32_W-1:0]  m_total_adverts;
    logic [OUTCNT_W-1:0] m_unique_count;
    logic m_table_overflow;
    logic [OUTCNT_W-1:0] m_random_unique_count;
    logic [CNT32_W-1:0]  m_busiest_hits;
    logic [KEY_W-1:0]    m_top_advertiser;
    logic [CNT32_W-1:0]  m_vendor_a_count;
    logic [CNT32_W-1:0]  m_vendor_b_count;
    logic [CNT32_W-1:0]  m_vendor_c_count;
    logic [CNT32_W-1:0]  m_vendor_d_count;
    logic [CNT32_W-1:0]  m_pairing_service_count;
    logic [CNT32_W-1:0]  m_other_vendor_count;

    advertiser_churn_tracker_unit #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_mode                 (s_mode),
        .s_advertiser_address   (s_advertiser_address),
        .s_address_type         (s_address_type),
        .s_company_present      (s_company_present),
        .s_company_code         (s_company_code),
        .s_service_present      (s_service_present),
        .s_service_code         (s_service_code),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_total_adverts        (m_total_adverts),
        .m_unique_count         (m_unique_count),
        .m_table_overflow       (m_table_overflow),
        .m_random_unique_count  (m_random_unique_count),
        .m_busiest_hits         (m_busiest_hits),
        .m_top_advertiser       (m_top_advertiser),
        .m_vendor_a_count       (m_vendor_a_count),
        .m_vendor_b_count       (m_vendor_b_count),
        .m_vendor_c_count       (m_vendor_c_count),
        .m_vendor_d_count       (m_vendor_d_count),
        .m_pairing_service_count(m_pairing_service_count),
        .m_other_vendor_count   (m_other_vendor_count)
    );

    // predictor state: one window of the tracker
    logic [KEY_W-1:0] key_tab [TABLE_DEPTH];
    logic [31:0]      hit_tab [TABLE_DEPTH];
    int               fill;
    bit               overflow;
    int               random_entries;
    int               top_slot;
    logic [31:0]      top_hits;
    logic [31:0]      adverts;
    logic [31:0]      tally_a, tally_b, tally_c, tally_d, tally_pair, tally_other;

    window_stats_t expected_stats[$];
    directed_row_t dir_rows [N_DIRECTED];
    int  mismatches;
    int  results_seen;
    int  overflow_results;
    int  peak_fill;
    int  beats_sent;
    int  clears_sent;
    int  cycle_count;
    bit  steady;

    always #5 aclk = ~aclk;

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic void clear_window();
        fill           = 0;
        overflow       = 1'b0;
        random_entries = 0;
        top_slot       = 0;
        top_hits       = '0;
        adverts        = '0;
        tally_a        = '0;
        tally_b        = '0;
        tally_c        = '0;
        tally_d        = '0;
        tally_pair     = '0;
        tally_other    = '0;
    endfunction

    function automatic window_stats_t predict_window(input advert_beat_t b);
        window_stats_t s;
        logic [KEY_W-1:0] key;
        int slot;
        bit found;
        found = 1'b0;
        slot  = 0;
        if (b.mode == MODE_CLEAR) begin
            clear_window();
        end else begin
            key     = {b.atype, b.addr};
            adverts = bump(adverts);
            if (b.co_present) begin
                case (b.co_code)
                    CID_A:   tally_a = bump(tally_a);
                    CID_B:   tally_b = bump(tally_b);
                    CID_C:   tally_c = bump(tally_c);
                    CID_D:   tally_d = bump(tally_d);
                    default: tally_other = bump(tally_other);
                endcase
            end
            if (b.svc_present && b.svc_code == SVC_PAIRING)
                tally_pair = bump(tally_pair);
            for (int i = 0; i < fill; i++) begin
                if (!found && key_tab[i] == key) begin
                    found = 1'b1;
                    slot  = i;
                end
            end
            if (found) begin
                hit_tab[slot] = bump(hit_tab[slot]);
                // strictly above: a tie leaves the current leader in place
                if (hit_tab[slot] > top_hits) begin
                    top_hits = hit_tab[slot];
                    top_slot = slot;
                end
            end else if (fill >= TABLE_DEPTH) begin
                overflow = 1'b1;
            end else begin
                key_tab[fill] = key;
                hit_tab[fill] = 32'd1;
                if (b.atype == ATYPE_RANDOM || b.atype == ATYPE_RANDOM_ID)
                    random_entries++;
                if (top_hits == '0) begin
                    top_hits = 32'd1;
                    top_slot = fill;
                end
                fill++;
            end
        end
        s.total      = adverts;
        s.uniq       = 9'(fill);
        s.ovf        = overflow;
        s.rnd        = 9'(random_entries);
        s.top_hits   = top_hits;
        s.top_key    = (top_hits != '0) ? key_tab[top_slot] : '0;
        s.vend_a     = tally_a;
        s.vend_b     = tally_b;
        s.vend_c     = tally_c;
        s.vend_d     = tally_d;
        s.pairing    = tally_pair;
        s.vend_other = tally_other;
        return s;
    endfunction

    function automatic advert_beat_t mk_beat(input logic m, input logic [ADDR_W-1:0] addr,
                                             input logic [TYPE_W-1:0] t, input logic cp,
                                             input logic [CODE_W-1:0] cc, input logic sp,
                                             input logic [CODE_W-1:0] sc);
        advert_beat_t b;
        b = '{mode: m, addr: addr, atype: t, co_present: cp, co_code: cc,
              svc_present: sp, svc_code: sc};
        return b;
    endfunction

    function automatic window_stats_t mk_stats(input int total, input int uniq, input bit ovf,
                                               input int rnd, input int top,
                                               input logic [KEY_W-1:0] top_key,
                                               input int a, input int b, input int c,
                                               input int d, input int pair, input int other);
        window_stats_t s;
        s = '{total: 32'(total), uniq: 9'(uniq), ovf: ovf, rnd: 9'(rnd),
              top_hits: 32'(top), top_key: top_key, vend_a: 32'(a), vend_b: 32'(b),
              vend_c: 32'(c), vend_d: 32'(d), pairing: 32'(pair), vend_other: 32'(other)};
        return s;
    endfunction

    // new_pct: share of fresh addresses; the rest repeat held keys, skewed to early slots
    function automatic advert_beat_t random_beat(input int new_pct, input int clear_per_mille);
        advert_beat_t b;
        int pick;
        b.mode = ($urandom_range(0, 999) < clear_per_mille) ? MODE_CLEAR : MODE_ADVERT;
        if (fill > 0 && $urandom_range(0, 99) >= new_pct) begin
            pick = $urandom_range(0, $urandom_range(0, fill - 1));
            {b.atype, b.addr} = key_tab[pick];
        end else begin
            b.addr  = {16'($urandom()), 32'($urandom())};
            b.atype = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 19) == 0)
                b.addr = $urandom_range(0, 1) ? '1 : '0;
        end
        b.co_present = ($urandom_range(0, 99) < 80);
        case ($urandom_range(0, 5))
            0:       b.co_code = CID_A;
            1:       b.co_code = CID_B;
            2:       b.co_code = CID_C;
            3:       b.co_code = CID_D;
            default: b.co_code = 16'($urandom());
        endcase
        b.svc_present = ($urandom_range(0, 99) < 60);
        b.svc_code    = $urandom_range(0, 1) ? SVC_PAIRING : 16'($urandom());
        return b;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_CAP)
            $display("MISMATCH @%0t result %0d %s: got 0x%0h want 0x%0h",
                     $realtime, results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // called right after a negedge-free return; drives at a falling edge, after a random gap unless steady
    task automatic send_beat(input advert_beat_t b, input window_stats_t want);
        int gap;
        gap = 0;
        while (!steady && $urandom_range(0, 99) < 36)
            gap++;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid              <= 1'b1;
        s_mode               <= b.mode;
        s_advertiser_address <= b.addr;
        s_address_type       <= b.atype;
        s_company_present    <= b.co_present;
        s_company_code       <= b.co_code;
        s_service_present    <= b.svc_present;
        s_service_code       <= b.svc_code;
        expected_stats.push_back(want);
        beats_sent++;
        if (b.mode == MODE_CLEAR)
            clears_sent++;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 36);
    end

    always @(posedge aclk) begin : result_check
        window_stats_t got;
        window_stats_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{total: m_total_adverts, uniq: m_unique_count, ovf: m_table_overflow,
                    rnd: m_random_unique_count, top_hits: m_busiest_hits,
                    top_key: m_top_advertiser, vend_a: m_vendor_a_count,
                    vend_b: m_vendor_b_count, vend_c: m_vendor_c_count,
                    vend_d: m_vendor_d_count, pairing: m_pairing_service_count,
                    vend_other: m_other_vendor_count};
            if (expected_stats.size() == 0) begin
                report_mismatch("unexpected beat", 64'(got.total), '0);
            end else begin
                want = expected_stats.pop_front();
                check_field("total_adverts", 64'(got.total), 64'(want.total));
                check_field("unique_count", 64'(got.uniq), 64'(want.uniq));
                check_field("table_overflow", 64'(got.ovf), 64'(want.ovf));
                check_field("random_unique_count", 64'(got.rnd), 64'(want.rnd));
                check_field("busiest_hits", 64'(got.top_hits), 64'(want.top_hits));
                check_field("top_advertiser", 64'(got.top_key), 64'(want.top_key));
                check_field("vendor_a_count", 64'(got.vend_a), 64'(want.vend_a));
                check_field("vendor_b_count", 64'(got.vend_b), 64'(want.vend_b));
                check_field("vendor_c_count", 64'(got.vend_c), 64'(want.vend_c));
                check_field("vendor_d_count", 64'(got.vend_d), 64'(want.vend_d));
                check_field("pairing_service_count", 64'(got.pairing), 64'(want.pairing));
                check_field("other_vendor_count", 64'(got.vend_other), 64'(want.vend_other));
                if (want.ovf)
                    overflow_results++;
                if (int'(want.uniq) > peak_fill)
                    peak_fill = int'(want.uniq);
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still pending",
                     cycle_count, expected_stats.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        advert_beat_t  b;
        window_stats_t predicted;

        aclk                 = 1'b0;
        aresetn              = 1'b0;
        s_valid              = 1'b0;
        s_mode               = MODE_ADVERT;
        s_advertiser_address = '0;
        s_address_type       = ATYPE_PUBLIC;
        s_company_present    = 1'b0;
        s_company_code       = '0;
        s_service_present    = 1'b0;
        s_service_code       = '0;
        m_ready              = 1'b0;
        steady               = 1'b0;
        mismatches           = 0;
        results_seen         = 0;
        overflow_results     = 0;
        peak_fill            = 0;
        beats_sent           = 0;
        clears_sent          = 0;
        cycle_count          = 0;
        clear_window();

        // clear with junk in the ignored fields, then leader / tie / vendor corner cases
        dir_rows[0]  = '{beat: mk_beat(MODE_CLEAR, '1, ATYPE_RANDOM_ID, 1'b1, CID_A, 1'b1,
                                       SVC_PAIRING), typed: 1'b1, want: '0};
        dir_rows[1]  = '{beat: mk_beat(MODE_ADVERT, '0, ATYPE_PUBLIC, 1'b1, CID_A, 1'b1,
                                       SVC_PAIRING), typed: 1'b1,
                         want: mk_stats(1, 1, 0, 0, 1, '0, 1, 0, 0, 0, 1, 0)};
        dir_rows[2]  = '{beat: mk_beat(MODE_ADVERT, '1, ATYPE_RANDOM_ID, 1'b1, CID_B, 1'b1,
                                       16'hFE2D), typed: 1'b1,
                         want: mk_stats(2, 2, 0, 1, 1, '0, 1, 1, 0, 0, 1, 0)};
        dir_rows[3]  = '{beat: mk_beat(MODE_ADVERT, '1, ATYPE_RANDOM_ID, 1'b1, CID_C, 1'b0,
                                       SVC_PAIRING), typed: 1'b0, want: '0};
        // tie with the leader must not take over
        dir_rows[4]  = '{beat: mk_beat(MODE_ADVERT, '0, ATYPE_PUBLIC, 1'b1, CID_D, 1'b1,
                                       16'h0000), typed: 1'b0, want: '0};
        dir_rows[5]  = '{beat: mk_beat(MODE_ADVERT, '0, ATYPE_PUBLIC, 1'b1, 16'hFFFF, 1'b1,
                                       16'hFFFF), typed: 1'b0, want: '0};
        // same address, other type: a separate entry; absent data tallies nothing
        dir_rows[6]  = '{beat: mk_beat(MODE_ADVERT, '0, ATYPE_RANDOM, 1'b0, CID_A, 1'b0,
                                       SVC_PAIRING), typed: 1'b0, want: '0};
        dir_rows[7]  = '{beat: mk_beat(MODE_ADVERT, 48'hAAAA_AAAA_AAAA, ATYPE_PUBLIC_ID,
                                       1'b1, 16'h0000, 1'b1, SVC_PAIRING),
                         typed: 1'b0, want: '0};
        dir_rows[8]  = '{beat: mk_beat(MODE_ADVERT, 48'h5555_5555_5555, ATYPE_RANDOM_ID,
                                       1'b1, 16'h4C00, 1'b1, 16'h2CFE),
                         typed: 1'b0, want: '0};
        dir_rows[9]  = '{beat: mk_beat(MODE_ADVERT, 48'h0000_0000_0001, ATYPE_RANDOM,
                                       1'b1, 16'h004D, 1'b0, SVC_PAIRING),
                         typed: 1'b0, want: '0};
        dir_rows[10] = '{beat: mk_beat(MODE_ADVERT, 48'h8000_0000_0000, ATYPE_PUBLIC,
                                       1'b1, CID_B, 1'b1, 16'h8000),
                         typed: 1'b0, want: '0};
        dir_rows[11] = '{beat: mk_beat(MODE_CLEAR, 48'h1234_5678_9ABC, ATYPE_RANDOM, 1'b1,
                                       CID_D, 1'b0, 16'hFFFF), typed: 1'b1, want: '0};
        dir_rows[12] = '{beat: mk_beat(MODE_ADVERT, 48'h1234_5678_9ABC, ATYPE_PUBLIC_ID,
                                       1'b1, CID_C, 1'b1, SVC_PAIRING), typed: 1'b1,
                         want: mk_stats(1, 1, 0, 0, 1, {ATYPE_PUBLIC_ID, 48'h1234_5678_9ABC},
                                        0, 0, 1, 0, 1, 0)};
        dir_rows[13] = '{beat: mk_beat(MODE_ADVERT, 48'h1234_5678_9ABC, ATYPE_PUBLIC_ID,
                                       1'b1, CID_A, 1'b1, SVC_PAIRING),
                         typed: 1'b0, want: '0};

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++) begin
            predicted = predict_window(dir_rows[r].beat);
            send_beat(dir_rows[r].beat, dir_rows[r].typed ? dir_rows[r].want : predicted);
        end

        // first stretch is mostly new addresses so the table fills and overflows
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 500) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                while (expected_stats.size() != 0)
                    @(posedge aclk);
            end
            steady = (i >= 600 && i < 750);
            b = random_beat((i < 350) ? 85 : 30, (i < 350) ? 0 : 5);
            if (i == 350)
                b.mode = MODE_CLEAR;
            predicted = predict_window(b);
            send_beat(b, predicted);
        end
        steady = 1'b0;

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_stats.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d beats (%0d window clears), checked %0d results, %0d mismatches",
                 beats_sent, clears_sent, results_seen, mismatches);
        $display("peak table fill %0d of %0d, %0d results with overflow flagged",
                 peak_fill, TABLE_DEPTH, overflow_results);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/act_pkg.sv
rtl/act_ctrl.sv
rtl/act_dp.sv
rtl/advertiser_churn_tracker_unit.sv
bench/tb_advertiser_churn_tracker_unit.sv
